// ===== design/opi_pkg.sv =====
package opi_pkg;

  // Sequencer states of the pose integrator.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_MAC,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  // Item modes as carried on the input tuser.
  localparam logic [2:0] MODE_MOVE    = 3'd0;
  localparam logic [2:0] MODE_SET_POSE = 3'd1;
  localparam logic [2:0] MODE_SET_X   = 3'd2;
  localparam logic [2:0] MODE_SET_Y   = 3'd3;
  localparam logic [2:0] MODE_SET_HEAD = 3'd4;
  localparam logic [2:0] MODE_CLEAR   = 3'd5;

  // Stream word widths.
  localparam int IN_W   = 224;
  localparam int OUT_W  = 176;
  localparam int USER_W = 3;

  // CORDIC geometry: Q4.30 vector, angle in 2^32 units per turn.
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int CORDIC_W     = 34;
  localparam int Z_W          = 33;
  localparam int TRIG_W       = 33;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Sine and cosine handed from the CORDIC to the multiply sequence.
  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  // Arctangent of 2^-i in 2^32 units per turn, rounded.
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [31:0] val;
    unique case (idx)
      4'd0:    val = 32'h2000_0000;
      4'd1:    val = 32'h12E4_051E;
      4'd2:    val = 32'h09FB_385B;
      4'd3:    val = 32'h0511_11D4;
      4'd4:    val = 32'h028B_0D43;
      4'd5:    val = 32'h0145_D7E1;
      4'd6:    val = 32'h00A2_F61E;
      4'd7:    val = 32'h0051_7C55;
      4'd8:    val = 32'h0028_BE53;
      4'd9:    val = 32'h0014_5F2F;
      4'd10:   val = 32'h000A_2F98;
      4'd11:   val = 32'h0005_17CC;
      4'd12:   val = 32'h0002_8BE6;
      4'd13:   val = 32'h0001_45F3;
      4'd14:   val = 32'h0000_A2FA;
      default: val = 32'h0000_517D;
    endcase
    return val;
  endfunction

endpackage

// ===== design/opi_cordic.sv =====
module opi_cordic
  import opi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] angle_i,
  output logic        done_o,
  output trig_t       trig_o
);

  logic                       busy_q;
  logic                       done_q;
  logic [STEP_W-1:0]          step_q;
  logic [1:0]                 quad_q;
  logic signed [CORDIC_W-1:0] x_q;
  logic signed [CORDIC_W-1:0] y_q;
  logic signed [Z_W-1:0]      z_q;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [Z_W-1:0]      atan_v;
  logic signed [TRIG_W-1:0]   xt;
  logic signed [TRIG_W-1:0]   yt;

  // One micro-rotation per cycle through a shared shifter and adder set.
  assign xs     = x_q >>> step_q;
  assign ys     = y_q >>> step_q;
  assign atan_v = signed'({1'b0, atan_turn(step_q)});

  // Sequencer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Vector and residual angle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quad_q <= angle_i[31:30];
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= signed'({3'b000, angle_i[29:0]});
    end else if (busy_q) begin
      if (!z_q[Z_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end
    end
  end

  // Fold the first-quadrant result back into the full turn.
  assign xt = x_q[TRIG_W-1:0];
  assign yt = y_q[TRIG_W-1:0];

  always_comb begin
    unique case (quad_q)
      2'd0: begin
        trig_o.cos_v = xt;
        trig_o.sin_v = yt;
      end
      2'd1: begin
        trig_o.cos_v = -yt;
        trig_o.sin_v = xt;
      end
      2'd2: begin
        trig_o.cos_v = -xt;
        trig_o.sin_v = -yt;
      end
      default: begin
        trig_o.cos_v = yt;
        trig_o.sin_v = -xt;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

// ===== design/odometry_pose_integrator.sv =====
// Channel   Dir  Word                                  Sideband
// s_axis    in   move or load item, 224 bits            tuser: mode
// m_axis    out  pose and wheel totals, 176 bits        none
//
// A move passes from acceptance through the CORDIC, the shared 32x33
// multiplier sequence, the saturating update and a state that presents the
// result; loads and clears go straight to the update and the result state.
// The input reopens in the cycle after the result is taken.
// Reset is asynchronous and active low; it restores the home pose.
// A stalled result holds the block until m_axis_tready is high.
module odometry_pose_integrator
  import opi_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int POS_BITS   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // dx, dy, dheading, left_step, right_step, new_x, new_y, new_heading
  input  logic [IN_W-1:0]   s_axis_tdata,
  // mode
  input  logic [USER_W-1:0] s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // pos_x_out, pos_y_out, heading_total, heading_wrapped, left_distance,
  // right_distance
  output logic [OUT_W-1:0]  m_axis_tdata
);

  localparam int PROD_W = 32 + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int TERM_W = SUM_W - 30;
  localparam int ADD_W  = ((POS_BITS > TERM_W) ? POS_BITS : TERM_W) + 1;
  localparam logic [31:0] HEAD_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic [31:0] HEAD_HOME = 32'(64'd1 << (ANGLE_BITS - 2));
  localparam logic signed [ADD_W-1:0] POS_HI =
    signed'({{(ADD_W - POS_BITS + 1){1'b0}}, {(POS_BITS - 1){1'b1}}});
  localparam logic signed [ADD_W-1:0] POS_LO = ~POS_HI;

  // Clamp a widened sum into the position range.
  function automatic logic signed [POS_BITS-1:0] sat_pos(
    input logic signed [ADD_W-1:0] v
  );
    logic signed [ADD_W-1:0] r;
    if (v > POS_HI) begin
      r = POS_HI;
    end else if (v < POS_LO) begin
      r = POS_LO;
    end else begin
      r = v;
    end
    return r[POS_BITS-1:0];
  endfunction

  state_e state_q, state_d;
  logic   accept;
  logic   cordic_start;
  logic   cordic_done;
  trig_t  trig;
  trig_t  trig_q;
  logic [2:0] mac_cnt_q;

  // Latched item fields.
  logic [2:0]         mode_q;
  logic signed [31:0] dx_q;
  logic signed [31:0] dy_q;
  logic signed [15:0] dheading_q;
  logic signed [31:0] left_step_q;
  logic signed [31:0] right_step_q;
  logic signed [31:0] new_x_q;
  logic signed [31:0] new_y_q;
  logic [15:0]        new_heading_q;

  // Pose state.
  logic signed [POS_BITS-1:0] pos_x_q;
  logic signed [POS_BITS-1:0] pos_y_q;
  logic [31:0]                heading_acc_q;
  logic signed [POS_BITS-1:0] left_total_q;
  logic signed [POS_BITS-1:0] right_total_q;

  // Multiply-accumulate datapath.
  logic signed [31:0]       mul_a;
  logic signed [TRIG_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q;
  logic signed [SUM_W-1:0]  sum_x_q;
  logic signed [SUM_W-1:0]  sum_y_q;
  logic signed [TERM_W-1:0] term_x;
  logic signed [TERM_W-1:0] term_y;
  logic [31:0]              head_wrap;
  logic [31:0]              head_load;

  assign accept       = s_axis_tvalid && s_axis_tready;
  assign cordic_start = accept && (s_axis_tuser == MODE_MOVE);
  assign head_wrap    = heading_acc_q & HEAD_MASK;
  assign head_load    = {16'd0, new_heading_q} & HEAD_MASK;

  opi_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (head_wrap << (32 - ANGLE_BITS)),
    .done_o  (cordic_done),
    .trig_o  (trig)
  );

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser == MODE_MOVE) ? ST_ROTATE : ST_UPDATE;
        end
      end
      ST_ROTATE: begin
        if (cordic_done) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_cnt_q == 3'd4) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Capture the item word on acceptance.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q        <= s_axis_tuser;
      dx_q          <= s_axis_tdata[31:0];
      dy_q          <= s_axis_tdata[63:32];
      dheading_q    <= s_axis_tdata[79:64];
      left_step_q   <= s_axis_tdata[111:80];
      right_step_q  <= s_axis_tdata[143:112];
      new_x_q       <= s_axis_tdata[175:144];
      new_y_q       <= s_axis_tdata[207:176];
      new_heading_q <= s_axis_tdata[223:208];
    end
  end

  // Operand selection: dy*cos, dx*sin, dx*cos, dy*sin in that order.
  assign mul_a = (mac_cnt_q == 3'd0 || mac_cnt_q == 3'd3) ? dy_q : dx_q;
  assign mul_b = (mac_cnt_q == 3'd0 || mac_cnt_q == 3'd2) ? trig_q.cos_v
                                                          : trig_q.sin_v;
  assign prod  = mul_a * mul_b;

  // Multiply sequence counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_cnt_q <= '0;
    end else if (state_q == ST_MAC) begin
      mac_cnt_q <= mac_cnt_q + 3'd1;
    end else begin
      mac_cnt_q <= '0;
    end
  end

  // Product register and the two rotated sums, one product behind.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROTATE && cordic_done) begin
      trig_q <= trig;
    end
    if (state_q == ST_MAC) begin
      prod_q <= prod;
      unique case (mac_cnt_q)
        3'd1:    acc_q   <= SUM_W'(prod_q);
        3'd2:    sum_x_q <= acc_q - SUM_W'(prod_q);
        3'd3:    acc_q   <= SUM_W'(prod_q);
        3'd4:    sum_y_q <= acc_q + SUM_W'(prod_q);
        default: acc_q   <= acc_q;
      endcase
    end
  end

  // Floor shift by 30 is the upper part of each sum.
  assign term_x = sum_x_q[SUM_W-1:30];
  assign term_y = sum_y_q[SUM_W-1:30];

  // Pose update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      heading_acc_q <= HEAD_HOME;
      left_total_q  <= '0;
      right_total_q <= '0;
    end else if (state_q == ST_UPDATE) begin
      unique case (mode_q)
        MODE_MOVE: begin
          pos_x_q       <= sat_pos(ADD_W'(pos_x_q) + ADD_W'(term_x));
          pos_y_q       <= sat_pos(ADD_W'(pos_y_q) + ADD_W'(term_y));
          heading_acc_q <= heading_acc_q + 32'(dheading_q);
          left_total_q  <= sat_pos(ADD_W'(left_total_q) + ADD_W'(left_step_q));
          right_total_q <= sat_pos(ADD_W'(right_total_q) + ADD_W'(right_step_q));
        end
        MODE_SET_POSE: begin
          pos_x_q       <= sat_pos(ADD_W'(new_x_q));
          pos_y_q       <= sat_pos(ADD_W'(new_y_q));
          heading_acc_q <= head_load;
        end
        MODE_SET_X: begin
          pos_x_q <= sat_pos(ADD_W'(new_x_q));
        end
        MODE_SET_Y: begin
          pos_y_q <= sat_pos(ADD_W'(new_y_q));
        end
        MODE_SET_HEAD: begin
          heading_acc_q <= head_load;
        end
        MODE_CLEAR: begin
          left_total_q  <= '0;
          right_total_q <= '0;
        end
        default: begin
          pos_x_q <= pos_x_q;
        end
      endcase
    end
  end

  // Result word, built from the pose registers.
  logic signed [ADD_W-1:0] px_ext;
  logic signed [ADD_W-1:0] py_ext;
  logic signed [ADD_W-1:0] lt_ext;
  logic signed [ADD_W-1:0] rt_ext;

  assign px_ext = ADD_W'(pos_x_q);
  assign py_ext = ADD_W'(pos_y_q);
  assign lt_ext = ADD_W'(left_total_q);
  assign rt_ext = ADD_W'(right_total_q);

  assign m_axis_tdata = {rt_ext[31:0], lt_ext[31:0], head_wrap[15:0],
                         heading_acc_q, py_ext[31:0], px_ext[31:0]};

endmodule

// ===== design/opi_checker.sv =====
module opi_checker
  import opi_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata
);

  // The block never takes a word while a result is on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  // Once a word is taken, the input closes for the work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still ready after acceptance");

  // After a result is taken, the block is ready for the next word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> (s_axis_tready && !m_axis_tvalid))
    else $error("block not idle after result delivery");

  // A stalled result holds its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind odometry_pose_integrator opi_checker u_opi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
